[hdl/tlov_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and command/status structs of the voxel bit store.
package tlov_pkg;

  localparam int MAX_VOXELS = 4096;
  localparam int NSLICES    = (MAX_VOXELS + 7) / 8;
  localparam int SLICE_W    = $clog2(NSLICES);
  localparam int VOX_W      = SLICE_W + 3;
  localparam int CFG_W      = 13;
  localparam int CRD_W      = 12;
  localparam int PROD_W     = CFG_W + CRD_W;
  localparam int ADR1_W     = PROD_W + 1;
  localparam int ADR2_W     = PROD_W + 2;

  localparam logic [2:0] REQ_SET   = 3'd0;
  localparam logic [2:0] REQ_GET   = 3'd1;
  localparam logic [2:0] REQ_DEPTH = 3'd2;
  localparam logic [2:0] REQ_OPT   = 3'd3;
  localparam logic [2:0] REQ_CLR   = 3'd4;

  localparam logic [1:0] CFG_SIZE_X     = 2'd0;
  localparam logic [1:0] CFG_LAYER_SIZE = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z     = 2'd2;

  localparam logic [1:0] LVL_VOXEL = 2'd0;
  localparam logic [1:0] LVL_SUB   = 2'd1;
  localparam logic [1:0] LVL_SSUB  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADR1, ST_ADR2, ST_CHK, ST_EXEC, ST_FILL, ST_CLR,
    ST_ORD, ST_OROW, ST_OSRD, ST_OSCK, ST_OWR
  } tlov_state_t;

  typedef enum logic [1:0] {RES_EXEC, RES_ERR, RES_ZERO} res_sel_t;

  typedef struct packed {
    logic               capture;
    logic               addr1;
    logic               addr2;
    logic               row_rd;
    logic               ss_rd;
    logic               use_idx;
    logic               exec;
    logic               fill;
    logic               clr_wr;
    logic               uni_upd;
    logic               opt_wr;
    logic               resp;
    res_sel_t           res_sel;
    logic [SLICE_W-1:0] idx;
    logic [2:0]         j;
  } tlov_cmd_t;

  typedef struct packed {
    logic [2:0] req;
    logic       range_err;
    logic       need_fill;
    logic       row_present;
    logic       row_split1;
    logic       row_split2;
  } tlov_sts_t;

endpackage

[hdl/tlov_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the voxel bit store: request flow, sweeps and result strobe.
module tlov_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tlov_pkg::tlov_sts_t sts,
  output tlov_pkg::tlov_cmd_t cmd,
  output logic                busy
);
  import tlov_pkg::*;

  tlov_state_t        state_r, state_nxt;
  logic [SLICE_W-1:0] idx_r, idx_nxt;
  logic [2:0]         j_r, j_nxt;
  logic               clr_pend_r, clr_pend_nxt;
  logic               last_idx;
  logic               opt_split;

  assign last_idx  = (idx_r == SLICE_W'(NSLICES - 1));
  assign opt_split = sts.row_present & sts.row_split1;
  assign busy      = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      idx_r      <= '0;
      j_r        <= '0;
      clr_pend_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      j_r        <= j_nxt;
      clr_pend_r <= clr_pend_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    j_nxt        = j_r;
    clr_pend_nxt = clr_pend_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_ADR1;
      ST_ADR1: begin
        unique case (sts.req) inside
          REQ_SET, REQ_GET, REQ_DEPTH: state_nxt = ST_ADR2;
          REQ_OPT: begin
            state_nxt = ST_ORD;
            idx_nxt   = '0;
          end
          REQ_CLR: begin
            state_nxt    = ST_CLR;
            idx_nxt      = '0;
            clr_pend_nxt = 1'b1;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_ADR2: state_nxt = ST_CHK;
      ST_CHK:  state_nxt = sts.range_err ? ST_IDLE : ST_EXEC;
      ST_EXEC: begin
        if (sts.need_fill) begin
          state_nxt = ST_FILL;
          j_nxt     = '0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (j_r == 3'd7) state_nxt = ST_IDLE;
        else j_nxt = j_r + 3'd1;
      end
      ST_CLR: begin
        if (last_idx) begin
          state_nxt    = ST_IDLE;
          clr_pend_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_ORD: state_nxt = ST_OROW;
      ST_OROW: begin
        if (opt_split) begin
          state_nxt = sts.row_split2 ? ST_OSRD : ST_OWR;
          j_nxt     = '0;
        end else if (last_idx) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_ORD;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      ST_OSRD: state_nxt = ST_OSCK;
      ST_OSCK: begin
        if (j_r == 3'd7) begin
          state_nxt = ST_OWR;
        end else begin
          state_nxt = ST_OSRD;
          j_nxt     = j_r + 3'd1;
        end
      end
      ST_OWR: begin
        if (last_idx) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_ORD;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd         = '0;
    cmd.res_sel = RES_ZERO;
    cmd.idx     = idx_r;
    cmd.j       = j_r;
    unique case (state_r)
      ST_IDLE: cmd.capture = start;
      ST_ADR1: begin
        cmd.addr1 = 1'b1;
        unique case (sts.req) inside
          REQ_SET, REQ_GET, REQ_DEPTH, REQ_OPT, REQ_CLR: cmd.resp = 1'b0;
          default: cmd.resp = 1'b1;
        endcase
      end
      ST_ADR2: cmd.addr2 = 1'b1;
      ST_CHK: begin
        if (sts.range_err) begin
          cmd.resp    = 1'b1;
          cmd.res_sel = RES_ERR;
        end else begin
          cmd.row_rd = 1'b1;
          cmd.ss_rd  = 1'b1;
        end
      end
      ST_EXEC: begin
        cmd.exec    = 1'b1;
        cmd.resp    = !sts.need_fill;
        cmd.res_sel = RES_EXEC;
      end
      ST_FILL: begin
        cmd.fill    = 1'b1;
        cmd.resp    = (j_r == 3'd7);
        cmd.res_sel = RES_EXEC;
      end
      ST_CLR: begin
        cmd.clr_wr  = 1'b1;
        cmd.use_idx = 1'b1;
        cmd.resp    = last_idx & clr_pend_r;
      end
      ST_ORD: begin
        cmd.row_rd  = 1'b1;
        cmd.use_idx = 1'b1;
      end
      ST_OROW: begin
        cmd.use_idx = 1'b1;
        cmd.resp    = !opt_split & last_idx;
      end
      ST_OSRD: begin
        cmd.ss_rd   = 1'b1;
        cmd.use_idx = 1'b1;
      end
      ST_OSCK: cmd.uni_upd = 1'b1;
      ST_OWR: begin
        cmd.opt_wr  = 1'b1;
        cmd.use_idx = 1'b1;
        cmd.resp    = last_idx;
      end
      default: cmd.resp = 1'b0;
    endcase
  end

endmodule

[hdl/tlov_dp.sv]
`timescale 1ns / 1ps
// Datapath of the voxel bit store: address math, slice and sub-sub memories, results.
module tlov_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tlov_pkg::tlov_cmd_t          cmd,
  output tlov_pkg::tlov_sts_t          sts,
  input  logic [2:0]                   in_req_type,
  input  logic [tlov_pkg::CRD_W-1:0]   in_coord_x,
  input  logic [tlov_pkg::CRD_W-1:0]   in_coord_y,
  input  logic [tlov_pkg::CRD_W-1:0]   in_coord_z,
  input  logic [1:0]                   in_level,
  input  logic [2:0]                   in_octant_one,
  input  logic [2:0]                   in_octant_two,
  input  logic                         in_set_value,
  input  logic                         cfg_valid,
  input  logic [1:0]                   cfg_index,
  input  logic [tlov_pkg::CFG_W-1:0]   cfg_data,
  output logic                         out_valid,
  output logic                         out_bit_value,
  output logic [1:0]                   out_depth,
  output logic                         out_is_split,
  output logic                         out_range_error
);
  import tlov_pkg::*;

  typedef struct packed {
    logic        present;
    logic        split1;
    logic        split2;
    logic [7:0]  vox;
    logic [63:0] sub;
  } row_t;

  function automatic logic [63:0] expand8(input logic [7:0] b);
    logic [63:0] w;
    for (int k = 0; k < 8; k++) w[k*8 +: 8] = {8{b[k]}};
    return w;
  endfunction

  // configuration
  logic [CFG_W-1:0] sx_r, ls_r, sz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= CFG_W'(1);
      ls_r <= CFG_W'(1);
      sz_r <= CFG_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SIZE_X:     sx_r <= cfg_data;
        CFG_LAYER_SIZE: ls_r <= cfg_data;
        CFG_SIZE_Z:     sz_r <= cfg_data;
        default:        sx_r <= sx_r;
      endcase
    end
  end

  // request capture
  logic [2:0]       req_r;
  logic [CRD_W-1:0] x_r, y_r, z_r;
  logic [1:0]       lvl_r;
  logic [2:0]       o1_r, o2_r;
  logic             data_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req_type;
      x_r    <= in_coord_x;
      y_r    <= in_coord_y;
      z_r    <= in_coord_z;
      lvl_r  <= (in_level == 2'd3) ? LVL_SSUB : in_level;
      o1_r   <= in_octant_one;
      o2_r   <= in_octant_two;
      data_r <= in_set_value;
    end
  end

  // linear index in two multiply stages
  logic [PROD_W-1:0] prod1, prod2;
  logic [ADR1_W-1:0] inlayer_r;
  logic [ADR2_W-1:0] vox_r;
  assign prod1 = sx_r * y_r;
  assign prod2 = ls_r * z_r;
  always_ff @(posedge clk) begin
    if (cmd.addr1) inlayer_r <= ADR1_W'(prod1) + ADR1_W'(x_r);
    if (cmd.addr2) vox_r <= ADR2_W'(inlayer_r) + ADR2_W'(prod2);
  end

  logic               range_err;
  logic [SLICE_W-1:0] s;
  logic [2:0]         v;
  assign range_err = ({1'b0, x_r} >= sx_r) || ({1'b0, z_r} >= sz_r) ||
                     (inlayer_r >= ADR1_W'(ls_r)) || (vox_r >= ADR2_W'(MAX_VOXELS));
  assign s = vox_r[VOX_W-1:3];
  assign v = vox_r[2:0];

  // memories
  row_t        row_mem [NSLICES];
  logic [63:0] ss_mem  [NSLICES*8];
  row_t        row_q;
  logic [63:0] w_q;

  logic [SLICE_W-1:0] row_addr;
  logic [VOX_W-1:0]   ss_addr;
  logic               row_we, ss_we;
  row_t               row_wdata;
  logic [63:0]        ss_wdata;

  assign row_addr = cmd.use_idx ? cmd.idx : s;

  always_ff @(posedge clk) begin
    if (row_we) row_mem[row_addr] <= row_wdata;
    if (cmd.row_rd) row_q <= row_mem[row_addr];
    if (ss_we) ss_mem[ss_addr] <= ss_wdata;
    if (cmd.ss_rd) w_q <= ss_mem[ss_addr];
  end

  // set / get evaluation
  logic        act, need_fill, ss_dir_we, get_bit;
  row_t        nr;
  logic [63:0] ss_new, ss_base;
  always_comb begin
    act       = (req_r == REQ_SET) && (data_r || row_q.present);
    nr        = row_q;
    need_fill = 1'b0;
    ss_dir_we = 1'b0;
    ss_new    = w_q;
    ss_base   = w_q;
    if (act) begin
      if (!row_q.present) begin
        nr.present = 1'b1;
        nr.vox     = '0;
        nr.split1  = 1'b0;
        nr.split2  = 1'b0;
      end
      case (lvl_r)
        LVL_VOXEL: begin
          nr.vox[v] = data_r;
          if (nr.split1) nr.sub[{v, 3'b000} +: 8] = {8{data_r}};
          ss_new    = {64{data_r}};
          ss_dir_we = nr.split1 & nr.split2;
        end
        LVL_SUB: begin
          if (!nr.split1) begin
            nr.sub    = expand8(nr.vox);
            nr.split1 = 1'b1;
          end
          nr.sub[{v, o1_r}] = data_r;
          ss_new[{o1_r, 3'b000} +: 8] = {8{data_r}};
          ss_dir_we = nr.split2;
        end
        default: begin
          if (!nr.split1) begin
            nr.sub    = expand8(nr.vox);
            nr.split1 = 1'b1;
          end
          need_fill = !nr.split2;
          ss_base   = nr.split2 ? w_q : expand8(nr.sub[{v, 3'b000} +: 8]);
          nr.split2 = 1'b1;
          ss_new    = ss_base;
          ss_new[{o1_r, o2_r}] = data_r;
          ss_dir_we = !need_fill;
        end
      endcase
    end
    if (!row_q.present) get_bit = 1'b0;
    else if (lvl_r == LVL_VOXEL || !row_q.split1) get_bit = row_q.vox[v];
    else if (lvl_r == LVL_SUB || !row_q.split2) get_bit = row_q.sub[{v, o1_r}];
    else get_bit = w_q[{o1_r, o2_r}];
  end

  // optimize: uniformity over the eight sub-sub words, then collapse
  logic uni_r, ref_r, ref_cur, eq;
  assign ref_cur = (cmd.j == 3'd0) ? w_q[0] : ref_r;
  assign eq      = (w_q == {64{ref_cur}});
  always_ff @(posedge clk) begin
    if (cmd.uni_upd) begin
      uni_r <= (cmd.j == 3'd0) ? eq : (uni_r & eq);
      ref_r <= ref_cur;
    end
  end

  row_t opt_row;
  logic keep;
  always_comb begin
    opt_row = row_q;
    keep    = 1'b1;
    if (row_q.split2) begin
      if (uni_r) begin
        opt_row.split2 = 1'b0;
        opt_row.sub    = {64{ref_r}};
      end else begin
        keep = 1'b0;
      end
    end
    if (keep && (opt_row.sub == {64{opt_row.sub[0]}})) begin
      opt_row.split1 = 1'b0;
      opt_row.vox    = {8{opt_row.sub[0]}};
    end
  end

  // write port selection
  always_comb begin
    row_we    = 1'b0;
    row_wdata = nr;
    if (cmd.clr_wr) begin
      row_we    = 1'b1;
      row_wdata = '0;
    end else if (cmd.opt_wr) begin
      row_we    = 1'b1;
      row_wdata = opt_row;
    end else if (cmd.exec) begin
      row_we = act;
    end
  end

  always_comb begin
    ss_we    = cmd.fill | (cmd.exec & ss_dir_we);
    ss_wdata = ss_new;
    if (cmd.fill) begin
      ss_addr = {s, cmd.j};
      if (cmd.j != v) ss_wdata = expand8(nr.sub[{cmd.j, 3'b000} +: 8]);
    end else if (cmd.use_idx) begin
      ss_addr = {cmd.idx, cmd.j};
    end else begin
      ss_addr = vox_r[VOX_W-1:0];
    end
  end

  assign sts.req         = req_r;
  assign sts.range_err   = range_err;
  assign sts.need_fill   = need_fill;
  assign sts.row_present = row_q.present;
  assign sts.row_split1  = row_q.split1;
  assign sts.row_split2  = row_q.split2;

  // result register
  logic       out_valid_r;
  logic       bit_r, split_r, err_r;
  logic [1:0] depth_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= cmd.resp;
    if (cmd.resp) begin
      case (cmd.res_sel)
        RES_EXEC: begin
          bit_r   <= (req_r == REQ_GET) ? get_bit : 1'b0;
          split_r <= nr.present & nr.split1;
          depth_r <= (nr.present & nr.split1) ? (nr.split2 ? 2'd2 : 2'd1) : 2'd0;
          err_r   <= 1'b0;
        end
        RES_ERR: begin
          bit_r   <= 1'b0;
          split_r <= 1'b0;
          depth_r <= 2'd0;
          err_r   <= 1'b1;
        end
        default: begin
          bit_r   <= 1'b0;
          split_r <= 1'b0;
          depth_r <= 2'd0;
          err_r   <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bit_value   = bit_r;
  assign out_depth       = depth_r;
  assign out_is_split    = split_r;
  assign out_range_error = err_r;

endmodule

[hdl/two_level_octree_voxel_bit_store_unit.sv]
`timescale 1ns / 1ps
// Top level of the two-level refined voxel bit store.
// Usage:
//  - Request channel: drive in_* and raise start; the transfer happens at the
//    clock edge where start is high and busy is low. busy stays high until
//    the request is finished, so one request is in flight at a time.
//  - Result channel: every request gives exactly one result, shown for one
//    cycle with out_valid high. The receiver cannot hold results off.
//  - Config channel: cfg_ready is always high; a transfer writes cfg_data to
//    register cfg_index (0 size_x, 1 layer_size, 2 size_z). Write only while
//    busy is low and no result is pending.
//  - Flow: set, get and depth query step through ADR1, ADR2, CHK and EXEC;
//    busy drops in the strobe cycle, so a new request waits for the result.
//    The two multiply stages of the linear index plus the registered read
//    of the slice memory make up these steps. Out-of-range requests strobe
//    from CHK. A level-2 set that creates the second split then fills the
//    slice (one write per voxel into the single-port sub-sub memory).
//  - Optimize walks all 512 slices and writes back each split slice, first
//    checking the sub-sub words if both splits are set. Clear zeroes all rows.
//  - Reset (rst_n low, synchronous) restores the config registers to 1 and
//    then runs a clearing pass over the slice memory with busy high.
module two_level_octree_voxel_bit_store_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 in_req_type,
  input  logic [tlov_pkg::CRD_W-1:0] in_coord_x,
  input  logic [tlov_pkg::CRD_W-1:0] in_coord_y,
  input  logic [tlov_pkg::CRD_W-1:0] in_coord_z,
  input  logic [1:0]                 in_level,
  input  logic [2:0]                 in_octant_one,
  input  logic [2:0]                 in_octant_two,
  input  logic                       in_set_value,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [tlov_pkg::CFG_W-1:0] cfg_data,
  output logic                       out_valid,
  output logic                       out_bit_value,
  output logic [1:0]                 out_depth,
  output logic                       out_is_split,
  output logic                       out_range_error
);
  import tlov_pkg::*;

  tlov_cmd_t cmd;
  tlov_sts_t sts;

  // registers are plain flops, so a config transfer is always taken
  assign cfg_ready = 1'b1;

  tlov_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tlov_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_req_type),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_coord_z      (in_coord_z),
    .in_level        (in_level),
    .in_octant_one   (in_octant_one),
    .in_octant_two   (in_octant_two),
    .in_set_value    (in_set_value),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_bit_value   (out_bit_value),
    .out_depth       (out_depth),
    .out_is_split    (out_is_split),
    .out_range_error (out_range_error)
  );

endmodule

[hdl/tlov_checker.sv]
`timescale 1ns / 1ps
// Port-level checker of the voxel bit store and its bind.
module tlov_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_bit_value,
  input logic [1:0] out_depth,
  input logic       out_is_split,
  input logic       out_range_error
);

  // reset always starts the clearing pass
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("block not busy after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a transfer");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |->
      (!out_bit_value && out_depth == 2'd0 && !out_is_split))
    else $error("range error result carries data");

  a_depth_split: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_depth != 2'd0) |-> out_is_split)
    else $error("nonzero depth without split");

endmodule

bind two_level_octree_voxel_bit_store_unit tlov_checker u_tlov_checker (.*);
